FILE: sv/contiguous_hole_allocator_top_assert.svh
// Assertion macros for the contiguous hole allocator.
// Used by contiguous_hole_allocator_top; expects clk and rst_n in scope.
`ifndef CONTIGUOUS_HOLE_ALLOCATOR_TOP_ASSERT_SVH
`define CONTIGUOUS_HOLE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define HCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hca_pkg.sv
// Package for the contiguous hole allocator: transaction types, codes, defaults.
// No dependencies.
package hca_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int MSIZE_W = 17;
    localparam int ID_W    = 16;
    localparam int SIZE_W  = 17;
    localparam int START_W = 16;
    localparam int END_W   = 17;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_COMPACT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CFG_MEMORY_SIZE = 1'b0;
    localparam logic CFG_FIT_MODE    = 1'b1;

    localparam logic [MSIZE_W-1:0] MEMORY_SIZE_RST = 17'd65536;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   block_id;
        logic [SIZE_W-1:0] alloc_len;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] start_addr;
        logic [END_W-1:0]   end_addr;
    } rsp_t;

endpackage

FILE: sv/contiguous_hole_allocator_top.sv
// Contiguous hole allocator, top level.
// Depends on hca_pkg and contiguous_hole_allocator_top_assert.svh.

// Keeps an address-sorted table of allocated blocks (owner id, base, length) in one
// synchronous entry RAM with a registered read. Allocate walks the holes from
// address 0 to the tail (first fit or best fit, ties to the higher address) and
// inserts the new entry by shifting later entries up; free finds the lowest entry
// with the id and shifts later entries down; compact rewrites every base end to end
// from 0. One transaction is worked at a time. Every RAM step is a read, then a
// use or write. A finished result sits in an output register, so a new request is
// taken while it waits to be collected. Configuration must be written only while
// idle; the block itself does not enforce this. memory_size above 2^ADDR_BITS acts
// as 2^ADDR_BITS.
module contiguous_hole_allocator_top #(
    parameter int MAX_BLOCKS = hca_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = hca_pkg::ADDR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  hca_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output hca_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [hca_pkg::MSIZE_W-1:0] cfg_data
);

    // length width: holds 2^ADDR_BITS and any request size
    localparam int LW = (ADDR_BITS + 1 > hca_pkg::SIZE_W) ? ADDR_BITS + 1 : hca_pkg::SIZE_W;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_EV  = 4'd2;
    localparam logic [3:0] S_PLACE    = 4'd3;
    localparam logic [3:0] S_SHIFT_RD = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_INSERT   = 4'd6;
    localparam logic [3:0] S_FSCAN_RD = 4'd7;
    localparam logic [3:0] S_FSCAN_EV = 4'd8;
    localparam logic [3:0] S_FSH_RD   = 4'd9;
    localparam logic [3:0] S_FSH_WR   = 4'd10;
    localparam logic [3:0] S_CMP_RD   = 4'd11;
    localparam logic [3:0] S_CMP_WR   = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    typedef struct packed {
        logic [hca_pkg::ID_W-1:0] owner;
        logic [LW-1:0]            base;
        logic [LW-1:0]            length;
    } entry_t;

    // entry RAM
    entry_t entry_mem [MAX_BLOCKS];
    entry_t rd_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [IW-1:0]   mem_raddr;
    entry_t          mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= entry_mem[mem_raddr];
    end

    // configuration
    logic [hca_pkg::MSIZE_W-1:0] msize_reg;
    logic                        fit_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg    <= hca_pkg::MEMORY_SIZE_RST;
            fit_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hca_pkg::CFG_MEMORY_SIZE)
            begin
                msize_reg <= cfg_data;
            end
            else
            begin
                fit_mode_reg <= cfg_data[0];
            end
        end
    end

    // control and working registers
    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            best_pos_reg, best_pos_next;
    logic                     found_reg, found_next;
    logic [LW-1:0]            prev_end_reg, prev_end_next;
    logic [LW-1:0]            best_len_reg, best_len_next;
    logic [LW-1:0]            best_start_reg, best_start_next;
    logic [hca_pkg::ID_W-1:0] id_reg, id_next;
    logic [LW-1:0]            size_reg, size_next;
    hca_pkg::rsp_t            res_reg, res_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    hca_pkg::rsp_t            rsp_reg, rsp_next;

    // hole evaluation
    logic [LW-1:0] mem_cap, mem_lim, hole_raw, hole_end, hole_len, blk_end;
    logic          hole_take;

    always_comb
    begin
        mem_cap  = LW'(1) << ADDR_BITS;
        mem_lim  = (LW'(msize_reg) > mem_cap) ? mem_cap : LW'(msize_reg);
        hole_raw = (state_reg == S_SCAN_EV) ? rd_reg.base : mem_lim;
        hole_end = (hole_raw > mem_lim) ? mem_lim : hole_raw;
        hole_len = (hole_end > prev_end_reg) ? hole_end - prev_end_reg : '0;
        blk_end  = rd_reg.base + rd_reg.length;
        if (hole_len < size_reg)
        begin
            hole_take = 1'b0;
        end
        else if (!fit_mode_reg)
        begin
            hole_take = !found_reg;
        end
        else
        begin
            hole_take = !found_reg || (hole_len <= best_len_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_pos_next   = best_pos_reg;
        found_next      = found_reg;
        prev_end_next   = prev_end_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IW-1:0];
        mem_raddr       = idx_reg[IW-1:0];
        mem_wdata       = rd_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    id_next       = req.block_id;
                    size_next     = LW'(req.alloc_len);
                    idx_next      = '0;
                    found_next    = 1'b0;
                    prev_end_next = '0;
                    res_next      = '{status: hca_pkg::ST_OK, start_addr: '0, end_addr: '0};
                    case (req.opcode)
                        hca_pkg::OP_ALLOC:
                        begin
                            if (count_reg >= CW'(MAX_BLOCKS))
                            begin
                                res_next.status = hca_pkg::ST_FULL;
                                state_next      = S_OUT;
                            end
                            else if (req.alloc_len == '0)
                            begin
                                res_next.status = hca_pkg::ST_NOFIT;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        hca_pkg::OP_FREE:    state_next = S_FSCAN_RD;
                        hca_pkg::OP_COMPACT: state_next = S_CMP_RD;
                        default:             state_next = S_OUT;
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                // tail hole once every entry has been seen
                if (idx_reg == count_reg)
                begin
                    if (hole_take)
                    begin
                        found_next      = 1'b1;
                        best_len_next   = hole_len;
                        best_start_next = prev_end_reg;
                        best_pos_next   = idx_reg;
                    end
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV:
            begin
                if (hole_take)
                begin
                    found_next      = 1'b1;
                    best_len_next   = hole_len;
                    best_start_next = prev_end_reg;
                    best_pos_next   = idx_reg;
                end
                prev_end_next = blk_end;
                idx_next      = idx_reg + 1'b1;
                state_next    = S_SCAN_RD;
            end

            S_PLACE:
            begin
                if (!found_reg)
                begin
                    res_next.status = hca_pkg::ST_NOFIT;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = (count_reg > best_pos_reg) ? S_SHIFT_RD : S_INSERT;
                end
            end

            S_SHIFT_RD:
            begin
                mem_raddr  = IW'(idx_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IW-1:0];
                mem_wdata  = rd_reg;
                idx_next   = idx_reg - 1'b1;
                state_next = ((idx_reg - 1'b1) > best_pos_reg) ? S_SHIFT_RD : S_INSERT;
            end

            S_INSERT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_pos_reg[IW-1:0];
                mem_wdata  = '{owner: id_reg, base: best_start_reg, length: size_reg};
                count_next = count_reg + 1'b1;
                res_next.status     = hca_pkg::ST_OK;
                res_next.start_addr = best_start_reg[hca_pkg::START_W-1:0];
                res_next.end_addr   = hca_pkg::END_W'(best_start_reg + size_reg);
                state_next = S_OUT;
            end

            S_FSCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next.status = hca_pkg::ST_NOTFOUND;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_FSCAN_EV;
                end
            end

            S_FSCAN_EV:
            begin
                if (rd_reg.owner == id_reg)
                begin
                    res_next.start_addr = rd_reg.base[hca_pkg::START_W-1:0];
                    res_next.end_addr   = blk_end[hca_pkg::END_W-1:0];
                    if ({1'b0, idx_reg} + (CW+1)'(1) < {1'b0, count_reg})
                    begin
                        state_next = S_FSH_RD;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FSCAN_RD;
                end
            end

            S_FSH_RD:
            begin
                mem_raddr  = IW'(idx_reg + 1'b1);
                state_next = S_FSH_WR;
            end

            S_FSH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IW-1:0];
                mem_wdata = rd_reg;
                idx_next  = idx_reg + 1'b1;
                if ({1'b0, idx_reg} + (CW+1)'(2) < {1'b0, count_reg})
                begin
                    state_next = S_FSH_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_OUT;
                end
            end

            S_CMP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next.end_addr = prev_end_reg[hca_pkg::END_W-1:0];
                    state_next        = S_OUT;
                end
                else
                begin
                    state_next = S_CMP_WR;
                end
            end

            S_CMP_WR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = idx_reg[IW-1:0];
                mem_wdata     = '{owner: rd_reg.owner, base: prev_end_reg,
                                  length: rd_reg.length};
                prev_end_next = prev_end_reg + rd_reg.length;
                idx_next      = idx_reg + 1'b1;
                state_next    = S_CMP_RD;
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_pos_reg   <= best_pos_next;
        found_reg      <= found_next;
        prev_end_reg   <= prev_end_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "contiguous_hole_allocator_top_assert.svh"

    `HCA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_BLOCKS), "entry count overflow")
    `HCA_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_reg != S_IDLE, "request lost")
    `HCA_ASSERT_NOW(a_insert_pos, state_reg == S_INSERT, best_pos_reg <= count_reg, "bad insert slot")
    `HCA_ASSERT_NOW(a_insert_room, state_reg == S_INSERT, count_reg < CW'(MAX_BLOCKS), "insert into full table")

endmodule
